### rtl/heap_timeout_queue_defines.svh
// heap_timeout_queue_defines.svh: assertion macros for the timer heap checker
// no dependencies
`ifndef HEAP_TIMEOUT_QUEUE_DEFINES_SVH
`define HEAP_TIMEOUT_QUEUE_DEFINES_SVH
// property that must hold at every edge out of reset
`define HTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked at every edge, reset included
`define HTQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### rtl/htq_pkg.sv
// htq_pkg: shared constants of the timer heap
// no dependencies
package htq_pkg;
  localparam int unsigned HeapDepthDef = 32;
  localparam int unsigned IdSpaceDef   = 256;
  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_FIRE  = 3'd1;
  localparam logic [2:0] MODE_ADJ   = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [19:0] DelayMax  = 20'hFFFFF;
endpackage

### rtl/htq_ram.sv
// htq_ram: generic single-port ram with registered read
// no dependencies
module htq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/heap_timeout_queue.sv
// heap_timeout_queue: top level, sequencer driving one compare-and-swap unit
// depends on htq_pkg and htq_ram (id-to-slot map)
//
// Usage: input beats on s_axis carry mode, timer_id and timeout_ms. Each beat
// produces zero or more expired-id beats (tuser=0) and one closing status beat
// (tuser=1, tlast=1) on m_axis. Only one input beat is worked on at a time;
// s_axis_tready is low until its status beat is taken.
// Sequence: the input beat is registered, the id-to-slot map ram is read in
// LOOK and the beat is dispatched in DISP. A sift-up level steps through
// parent pick (UP_CMP) and compare-and-swap (SWAP), a sift-down level through
// left child (DN_CMP), child select (DN_SEL) and compare-and-swap (SWAP);
// child select and compare-and-swap share the one comparator. A fire or each
// timer that a tick expires adds an id beat and a deletion.
// Reset empties the heap, forgets every id and zeroes the ms counter, with no
// sweep. A stalled receiver holds the output register and the sequencer waits
// for it.
module heap_timeout_queue #(
  parameter int unsigned HEAP_DEPTH = htq_pkg::HeapDepthDef,
  parameter int unsigned ID_SPACE   = htq_pkg::IdSpaceDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // mode[2:0], timer_id[10:3], timeout_ms[30:11]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // expired_id[7:0], next_delay[28:8],
                                     // entry_count[34:29], error_code[36:35]
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast   // last
);
  localparam int unsigned SW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW = (ID_SPACE > 256) ? 8 : $clog2(ID_SPACE);

  typedef enum logic [3:0] {
    IDLE, LOOK, DISP, UP_CMP, DN_CMP, DN_SEL, SWAP, AFTER, TICK_CHK,
    DEL, OUT_ID, STATUS, WAIT_OUT
  } state_t;

  state_t state;
  logic [2:0] mode;
  logic [7:0] tid;
  logic [19:0] tmo;
  logic [31:0] now_ms;
  logic [CW-1:0] size;
  logic [31:0] hexp [HEAP_DEPTH];
  logic [7:0]  hown [HEAP_DEPTH];
  logic [ID_SPACE-1:0] present;
  logic [1:0] err;
  logic [SW-1:0] cur, oth, start;
  logic up_dir, down_only, tried_down, moved;
  logic [7:0] emit_id;

  // children of cur
  logic [SW:0] c1, c2;
  assign c1 = {cur, 1'b1};
  assign c2 = {cur, 1'b0} + (SW+1)'(2);

  // shared compare unit: operands picked by the sequencer state
  logic [31:0] ka, kb;
  logic lt;
  assign lt = ka < kb;

  // id map ram
  logic map_we;
  logic [IW-1:0] map_addr;
  logic [SW-1:0] map_wdata, map_rdata;
  htq_ram #(.WIDTH(SW), .DEPTH(1 << IW)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
  );

  logic [IW-1:0] id_idx;
  logic id_ok, known;
  assign id_idx = tid[IW-1:0];
  assign id_ok  = (32'(tid) < ID_SPACE);
  assign known  = id_ok && present[id_idx];

  // write pending map update after a swap (two entries, done in SWAP and after it) or a tail move in DEL
  logic [SW-1:0] pend_slot;
  logic [7:0] pend_id;
  logic pend;

  // tail slot, swap and move decisions, output register load
  logic [CW-1:0] size_dec;
  logic [SW-1:0] tail;
  logic swap_go, del_move, out_load;
  assign size_dec = size - CW'(1);
  assign tail     = size_dec[SW-1:0];
  assign swap_go  = (state == SWAP) && !lt;
  assign del_move = (state == DEL) && (CW'(cur) < size_dec);
  assign out_load = ((state == OUT_ID) || (state == STATUS)) &&
                    (!m_axis_tvalid || m_axis_tready);

  // status fields
  logic [20:0] delay;
  always_comb begin
    if (size == '0) delay = '1;
    else if (hexp[0] <= now_ms) delay = '0;
    else if ((hexp[0] - now_ms) > 32'(htq_pkg::DelayMax)) delay = {1'b0, htq_pkg::DelayMax};
    else delay = 21'(hexp[0] - now_ms);
  end

  // comparator operands: right child vs left in child select, parent vs cur going up
  always_comb begin
    ka = hexp[cur];
    kb = hexp[oth];
    if (state == DN_SEL) ka = hexp[c2[SW-1:0]];
    else if (state == SWAP && up_dir) begin
      ka = hexp[oth];
      kb = hexp[cur];
    end
  end

  always_comb begin
    map_we = 1'b0;
    map_addr = id_idx;
    map_wdata = cur;
    if (pend) begin
      map_we = 1'b1;
      map_addr = pend_id[IW-1:0];
      map_wdata = pend_slot;
    end else if (swap_go) begin
      map_we = 1'b1;
      map_addr = hown[oth][IW-1:0];
      map_wdata = cur;
    end else if (state == DISP && mode == htq_pkg::MODE_ADD && id_ok && !known
                 && size < CW'(HEAP_DEPTH)) begin
      map_we = 1'b1;
      map_wdata = size[SW-1:0];
    end
  end

  assign s_axis_tready = (state == IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      now_ms <= '0;
      size <= '0;
      present <= '0;
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= swap_go || del_move;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        IDLE: if (s_axis_tvalid) begin
          mode <= s_axis_tdata[2:0];
          tid <= s_axis_tdata[10:3];
          tmo <= s_axis_tdata[30:11];
          err <= htq_pkg::ERR_OK;
          state <= LOOK;
        end
        LOOK: begin
          if (mode == htq_pkg::MODE_TICK) now_ms <= now_ms + 32'd1;
          state <= DISP;
        end
        DISP: begin
          down_only <= (mode == htq_pkg::MODE_ADJ);
          tried_down <= (mode == htq_pkg::MODE_ADD) && id_ok && !known;
          moved <= 1'b0;
          case (mode)
            htq_pkg::MODE_ADD: begin
              if (known) begin
                hexp[map_rdata] <= now_ms + 32'(tmo);
                cur <= map_rdata;
                start <= map_rdata;
                state <= DN_CMP;
              end else if (id_ok && size < CW'(HEAP_DEPTH)) begin
                hexp[size[SW-1:0]] <= now_ms + 32'(tmo);
                hown[size[SW-1:0]] <= tid;
                present[id_idx] <= 1'b1;
                size <= size + CW'(1);
                cur <= size[SW-1:0];
                start <= size[SW-1:0];
                state <= UP_CMP;
              end else begin
                if (id_ok) err <= htq_pkg::ERR_FULL;
                state <= STATUS;
              end
            end
            htq_pkg::MODE_FIRE: if (known) begin
              emit_id <= tid;
              cur <= map_rdata;
              state <= OUT_ID;
            end else state <= STATUS;
            htq_pkg::MODE_ADJ: if (known) begin
              hexp[map_rdata] <= now_ms + 32'(tmo);
              cur <= map_rdata;
              start <= map_rdata;
              state <= DN_CMP;
            end else begin
              err <= htq_pkg::ERR_UNKNOWN;
              state <= STATUS;
            end
            htq_pkg::MODE_TICK: state <= TICK_CHK;
            htq_pkg::MODE_CLEAR: begin
              size <= '0;
              present <= '0;
              state <= STATUS;
            end
            default: state <= STATUS;
          endcase
        end
        TICK_CHK: begin
          if (size != '0 && hexp[0] <= now_ms) begin
            emit_id <= hown[0];
            cur <= '0;
            state <= OUT_ID;
          end else state <= STATUS;
        end
        OUT_ID: if (out_load) begin
          m_axis_tdata <= {3'b0, 37'(emit_id)};
          m_axis_tuser <= 1'b0;
          m_axis_tlast <= 1'b0;
          state <= DEL;
        end
        DEL: begin
          // move tail into hole cur, then sift down, else up
          present[hown[cur][IW-1:0]] <= 1'b0;
          if (del_move) begin
            hexp[cur] <= hexp[tail];
            hown[cur] <= hown[tail];
            pend_id <= hown[tail];
            pend_slot <= cur;
            start <= cur;
            state <= DN_CMP;
          end else state <= (mode == htq_pkg::MODE_TICK) ? TICK_CHK : STATUS;
          size <= size_dec;
        end
        DN_CMP: begin
          // left child into oth
          if ({1'b0, c1} < (SW+2)'(size)) begin
            oth <= c1[SW-1:0];
            state <= DN_SEL;
          end else state <= AFTER;
        end
        DN_SEL: begin
          // right child wins if present and strictly smaller
          if ({1'b0, c2} < (SW+2)'(size) && lt)
            oth <= c2[SW-1:0];
          up_dir <= 1'b0;
          state <= SWAP;
        end
        UP_CMP: begin
          if (cur == '0) state <= AFTER;
          else begin
            oth <= (cur - SW'(1)) >> 1;
            up_dir <= 1'b1;
            state <= SWAP;
          end
        end
        SWAP: begin
          // up: stop if parent below cur; down: stop if cur below child
          if (lt) begin
            state <= AFTER;
          end else begin
            hexp[cur] <= hexp[oth];
            hown[cur] <= hown[oth];
            hexp[oth] <= hexp[cur];
            hown[oth] <= hown[cur];
            pend_id <= hown[cur];
            pend_slot <= oth;
            cur <= oth;
            moved <= 1'b1;
            state <= up_dir ? UP_CMP : DN_CMP;
          end
        end
        AFTER: begin
          // unmoved after sifting down (adjust excepted): try up from the start slot
          if (!tried_down && !down_only && !moved) begin
            tried_down <= 1'b1;
            cur <= start;
            state <= UP_CMP;
          end else begin
            tried_down <= 1'b0;
            moved <= 1'b0;
            state <= (mode == htq_pkg::MODE_TICK) ? TICK_CHK : STATUS;
          end
        end
        STATUS: if (out_load) begin
          m_axis_tdata <= {3'b0, err, 6'(size), delay, 8'd0};
          m_axis_tuser <= 1'b1;
          m_axis_tlast <= 1'b1;
          state <= WAIT_OUT;
        end
        WAIT_OUT: if (m_axis_tready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

### rtl/htq_checker.sv
// htq_checker: port-level assertions for heap_timeout_queue, bound to the top
// depends on heap_timeout_queue_defines.svh
`include "heap_timeout_queue_defines.svh"
module htq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  `HTQ_ASSERT(a_last_is_status, m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser), "tlast/tuser mismatch")
  `HTQ_ASSERT(a_id_clean, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[39:8] == '0), "id beat not clean")
  `HTQ_ASSERT(a_no_accept_busy, (m_axis_tvalid && !m_axis_tuser) |-> !s_axis_tready, "accepted while busy")
  `HTQ_ASSERT_RST(a_rst_idle, rst |=> !m_axis_tvalid, "output valid after reset")
endmodule

bind heap_timeout_queue htq_checker u_htq_checker (.*);
